>>> sv/ptrc_pkg.sv
`default_nettype none
package ptrc_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned FMT_W = 3;

	typedef enum logic [FMT_W-1:0] {
		FMT_PAL4   = 3'd0,
		FMT_PAL8   = 3'd1,
		FMT_RGB565 = 3'd2,
		FMT_RGB24  = 3'd3,
		FMT_BGR24  = 3'd4,
		FMT_RGBA32 = 3'd5
	} fmt_t;

	// stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} adv_t;

endpackage
`default_nettype wire

>>> sv/ptrc_if.sv
`default_nettype none
interface ptrc_pix_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] pixel_word;
	logic        single_pixel;
	logic        end_of_row;
	logic [7:0]  entry_index;
	logic [7:0]  entry_red;
	logic [7:0]  entry_green;
	logic [7:0]  entry_blue;

	modport source (
		output valid, op, pixel_word, single_pixel, end_of_row,
		output entry_index, entry_red, entry_green, entry_blue,
		input  ready
	);
	modport sink (
		input  valid, op, pixel_word, single_pixel, end_of_row,
		input  entry_index, entry_red, entry_green, entry_blue,
		output ready
	);
endinterface

interface ptrc_rgba_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       run_last;
	logic       row_done;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha, run_last, row_done,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha, run_last, row_done,
		output ready
	);
endinterface
`default_nettype wire

>>> sv/pixel_to_rgba8888_converter.sv
// path: a result passes stage registers s1 to s7 in order, and waits there under stall
// throughput: one input word per cycle unless the output stalls; a two-pixel pal4
// word holds its output until both pixels go, as the output gives one pixel per cycle
// the un-premultiply divide runs two quotient bits per stage over four stages
// reset clears all stage valid bits, the output beat and fmt_q (pal4);
// the palette is not cleared and holds nothing defined until written
`default_nettype none
module pixel_to_rgba8888_converter #(
	parameter int unsigned PALETTE_ENTRIES = ptrc_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [ptrc_pkg::FMT_W-1:0] cfg_wr_data,
	ptrc_pix_if.sink                        pix,
	ptrc_rgba_if.source                     rgba
);
	import ptrc_pkg::*;

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

	typedef struct packed {
		logic [23:0] col0;
		logic [23:0] col1;
		logic [7:0]  alpha;
		logic        two;
		logic        eor;
		logic        unpm;
	} side_t;

	fmt_t        fmt_q;
	adv_t        adv;
	logic        v1, v2, v3, v4, v5, v6, v7;
	logic        phase_q;
	logic        last_beat;

	logic        op_s1, single_s1, eor_s1;
	logic [31:0] word_s1;
	logic [7:0]  idx_s1;
	logic [23:0] ent_s1;

	logic        single_s2, eor_s2, pal_ok_s2;
	logic [23:0] dir_s2;
	logic [7:0]  alpha_s2;
	logic [23:0] dir_n;
	logic [23:0] rd0, rd1;

	side_t       side_n, side_s3, side_s4, side_s5, side_s6;
	logic [23:0] pix0_s7, pix1_s7;
	logic [7:0]  alpha_s7;
	logic        two_s7, eor_s7;
	logic [7:0]  q_red, q_green, q_blue;
	logic [23:0] cur;

	logic          pal_we;
	logic [AW-1:0] raddr0, raddr1;

	// stall chain: a stage loads when empty or when it hands its item on
	assign last_beat = !two_s7 || phase_q;
	always_comb begin
		adv.s7 = !v7 || (rgba.ready && last_beat);
		adv.s6 = !v6 || adv.s7;
		adv.s5 = !v5 || adv.s6;
		adv.s4 = !v4 || adv.s5;
		adv.s3 = !v3 || adv.s4;
		adv.s2 = !v2 || adv.s3;
		adv.s1 = !v1 || adv.s2;
	end
	assign pix.ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_PAL4;
			v1      <= 1'b0;
			v2      <= 1'b0;
			v3      <= 1'b0;
			v4      <= 1'b0;
			v5      <= 1'b0;
			v6      <= 1'b0;
			v7      <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fmt_q <= fmt_t'(cfg_wr_data);
			end
			if (adv.s1) v1 <= pix.valid;
			// palette writes leave the pipeline here
			if (adv.s2) v2 <= v1 && !op_s1;
			if (adv.s3) v3 <= v2;
			if (adv.s4) v4 <= v3;
			if (adv.s5) v5 <= v4;
			if (adv.s6) v6 <= v5;
			if (adv.s7) v7 <= v6;
			if (adv.s7) begin
				phase_q <= 1'b0;
			end else if (v7 && rgba.ready) begin
				phase_q <= 1'b1;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			op_s1     <= pix.op;
			word_s1   <= pix.pixel_word;
			single_s1 <= pix.single_pixel;
			eor_s1    <= pix.end_of_row;
			idx_s1    <= pix.entry_index;
			ent_s1    <= {pix.entry_red, pix.entry_green, pix.entry_blue};
		end
	end

	// stage 2: palette access, direct formats, divide setup
	assign pal_we = adv.s2 && v1 && op_s1 && ({1'b0, idx_s1} < 9'(PALETTE_ENTRIES));
	assign raddr0 = (fmt_q == FMT_PAL4) ? AW'(word_s1[7:4]) : word_s1[AW-1:0];
	assign raddr1 = AW'(word_s1[3:0]);

	ptrc_palette #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk    (clk),
		.en     (adv.s2),
		.we     (pal_we),
		.waddr  (idx_s1[AW-1:0]),
		.wdata  (ent_s1),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	always_comb begin
		case (fmt_q)
			FMT_RGB565: dir_n = {word_s1[15:11], 3'b000, word_s1[10:5], 2'b00,
				word_s1[4:0], 3'b000};
			FMT_RGB24:  dir_n = word_s1[23:0];
			FMT_BGR24:  dir_n = {word_s1[7:0], word_s1[15:8], word_s1[23:16]};
			default:    dir_n = 24'h000000;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			single_s2 <= single_s1;
			eor_s2    <= eor_s1;
			dir_s2    <= dir_n;
			alpha_s2  <= word_s1[31:24];
			pal_ok_s2 <= {1'b0, word_s1[7:0]} < 9'(PALETTE_ENTRIES);
		end
	end

	ptrc_unpremul u_red (
		.clk (clk), .adv (adv), .c (word_s1[23:16]), .a (word_s1[31:24]), .quo (q_red)
	);
	ptrc_unpremul u_green (
		.clk (clk), .adv (adv), .c (word_s1[15:8]), .a (word_s1[31:24]), .quo (q_green)
	);
	ptrc_unpremul u_blue (
		.clk (clk), .adv (adv), .c (word_s1[7:0]), .a (word_s1[31:24]), .quo (q_blue)
	);

	// stage 3: pick colors per format, carry them beside the divider
	always_comb begin
		side_n       = '0;
		side_n.eor   = eor_s2;
		side_n.alpha = 8'hFF;
		case (fmt_q)
			FMT_PAL4: begin
				side_n.col0 = rd0;
				side_n.col1 = rd1;
				side_n.two  = !single_s2;
			end
			FMT_PAL8: begin
				side_n.col0 = pal_ok_s2 ? rd0 : 24'h000000;
			end
			FMT_RGB565, FMT_RGB24, FMT_BGR24: begin
				side_n.col0 = dir_s2;
			end
			FMT_RGBA32: begin
				side_n.alpha = alpha_s2;
				side_n.unpm  = 1'b1;
			end
			default: begin
				side_n.alpha = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s3) side_s3 <= side_n;
		if (adv.s4) side_s4 <= side_s3;
		if (adv.s5) side_s5 <= side_s4;
		if (adv.s6) side_s6 <= side_s5;
	end

	// stage 7: output register, zero alpha keeps the all-zero color
	always_ff @(posedge clk) begin
		if (adv.s7) begin
			pix0_s7  <= (side_s6.unpm && side_s6.alpha != 8'h00) ?
				{q_red, q_green, q_blue} : side_s6.col0;
			pix1_s7  <= side_s6.col1;
			alpha_s7 <= side_s6.alpha;
			two_s7   <= side_s6.two;
			eor_s7   <= side_s6.eor;
		end
	end

	assign cur            = phase_q ? pix1_s7 : pix0_s7;
	assign rgba.valid     = v7;
	assign rgba.out_red   = cur[23:16];
	assign rgba.out_green = cur[15:8];
	assign rgba.out_blue  = cur[7:0];
	assign rgba.out_alpha = alpha_s7;
	assign rgba.run_last  = last_beat;
	assign rgba.row_done  = eor_s7 && last_beat;

	a_phase_two: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (v7 && two_s7))
		else $error("second pixel beat without a two-pixel word");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v1 && op_s1 && adv.s2) |=> !v2)
		else $error("palette write entered the result path");

	a_two_only_pal4: assert property (@(posedge clk) disable iff (!arst_n)
		(rgba.valid && !rgba.run_last) |-> (fmt_q == FMT_PAL4))
		else $error("first of two pixels outside pal4 mode");

	a_row_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rgba.valid && rgba.row_done) |-> rgba.run_last)
		else $error("row end flagged before the last pixel of a word");

endmodule
`default_nettype wire

>>> sv/ptrc_palette.sv
`default_nettype none
module ptrc_palette #(
	parameter int unsigned ENTRIES = ptrc_pkg::PALETTE_ENTRIES_DEF,
	localparam int unsigned AW = $clog2(ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [23:0]   wdata,
	input  wire logic [AW-1:0] raddr0,
	input  wire logic [AW-1:0] raddr1,
	output logic      [23:0]   rdata0,
	output logic      [23:0]   rdata1
);
	import ptrc_pkg::*;

	logic [23:0] mem [0:ENTRIES-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data only moves when the stage it feeds advances
	always_ff @(posedge clk) begin
		if (en) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule
`default_nettype wire

>>> sv/ptrc_unpremul.sv
`default_nettype none
module ptrc_unpremul (
	input  wire logic           clk,
	input  wire ptrc_pkg::adv_t adv,
	input  wire logic [7:0]     c,
	input  wire logic [7:0]     a,
	output logic      [7:0]     quo
);
	import ptrc_pkg::*;

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [16:0] dstep(input logic [15:0] rem, input logic [7:0] den,
			input int unsigned sh);
		logic [15:0] t;
		t = 16'({8'h00, den} << sh);
		if (rem >= t) begin
			dstep = {1'b1, rem - t};
		end else begin
			dstep = {1'b0, rem};
		end
	endfunction

	logic [15:0] num_n;
	logic [15:0] num_s2;
	logic [7:0]  den_s2, den_s3, den_s4, den_s5;
	logic        sat_s2, sat_s3, sat_s4, sat_s5, sat_s6;
	logic [15:0] rem_s3, rem_s4, rem_s5;
	logic [7:0]  quo_s3, quo_s4, quo_s5, quo_s6;
	logic [16:0] t3a, t3b, t4a, t4b, t5a, t5b, t6a, t6b;

	// c*255 + a/2
	assign num_n = {c, 8'h00} - {8'h00, c} + {9'h000, a[7:1]};

	always_comb begin
		t3a = dstep(num_s2, den_s2, 7);
		t3b = dstep(t3a[15:0], den_s2, 6);
		t4a = dstep(rem_s3, den_s3, 5);
		t4b = dstep(t4a[15:0], den_s3, 4);
		t5a = dstep(rem_s4, den_s4, 3);
		t5b = dstep(t5a[15:0], den_s4, 2);
		t6a = dstep(rem_s5, den_s5, 1);
		t6b = dstep(t6a[15:0], den_s5, 0);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			num_s2 <= num_n;
			den_s2 <= a;
			// quotient would not fit in eight bits
			sat_s2 <= num_n >= {a, 8'h00};
		end
		if (adv.s3) begin
			rem_s3 <= t3b[15:0];
			quo_s3 <= {t3a[16], t3b[16], 6'b000000};
			den_s3 <= den_s2;
			sat_s3 <= sat_s2;
		end
		if (adv.s4) begin
			rem_s4 <= t4b[15:0];
			quo_s4 <= {quo_s3[7:6], t4a[16], t4b[16], 4'b0000};
			den_s4 <= den_s3;
			sat_s4 <= sat_s3;
		end
		if (adv.s5) begin
			rem_s5 <= t5b[15:0];
			quo_s5 <= {quo_s4[7:4], t5a[16], t5b[16], 2'b00};
			den_s5 <= den_s4;
			sat_s5 <= sat_s4;
		end
		if (adv.s6) begin
			quo_s6 <= {quo_s5[7:2], t6a[16], t6b[16]};
			sat_s6 <= sat_s5;
		end
	end

	assign quo = sat_s6 ? 8'hFF : quo_s6;

endmodule
`default_nettype wire

>>> verif/pixel_to_rgba8888_converter_tb.sv
module pixel_to_rgba8888_converter_tb;
	import ptrc_pkg::*;

	localparam logic OP_CONVERT   = 1'b0;
	localparam logic OP_PAL_WRITE = 1'b1;
	// codes the enum leaves out; the block answers them with a blank pixel
	localparam logic [FMT_W-1:0] FMT_UNDEF_6 = 3'd6;
	localparam logic [FMT_W-1:0] FMT_UNDEF_7 = 3'd7;

	typedef struct packed {
		logic        op;
		logic [31:0] word;
		logic        single;
		logic        eor;
		logic [7:0]  idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
		logic       row;
	} rgba_px_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [FMT_W-1:0] cfg_wr_data;

	ptrc_pix_if  pix ();
	ptrc_rgba_if rgba ();

	pixel_to_rgba8888_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pix         (pix),
		.rgba        (rgba)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [23:0]      clut_shadow [256];
	logic [FMT_W-1:0] fmt_shadow = FMT_PAL4;
	rgba_px_t         pixels_due [$];
	int               mismatches = 0;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               hold_request = 0;

	function automatic int draw_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
		int unsigned v;
		v = (int'(c) * 255 + int'(a) / 2) / int'(a);
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	function automatic void push_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a, logic last, logic row);
		pixels_due.push_back('{red: r, green: g, blue: b, alpha: a, last: last, row: row});
	endfunction

	function automatic void push_clut(logic [7:0] idx, logic last, logic row);
		logic [23:0] e;
		e = clut_shadow[idx];
		push_px(e[23:16], e[15:8], e[7:0], 8'hFF, last, row);
	endfunction

	// expected pixels for one accepted transfer, in output order
	function automatic void expand_word(pix_req_t req);
		logic [7:0]  b0, b1, b2, b3;
		logic [15:0] p;
		b0 = req.word[7:0];
		b1 = req.word[15:8];
		b2 = req.word[23:16];
		b3 = req.word[31:24];
		p  = req.word[15:0];
		if (req.op == OP_PAL_WRITE) begin
			clut_shadow[req.idx] = {req.red, req.green, req.blue};
			return;
		end
		case (fmt_shadow)
			FMT_PAL4: begin
				if (req.single) begin
					push_clut({4'h0, b0[7:4]}, 1'b1, req.eor);
				end else begin
					push_clut({4'h0, b0[7:4]}, 1'b0, 1'b0);
					push_clut({4'h0, b0[3:0]}, 1'b1, req.eor);
				end
			end
			FMT_PAL8: push_clut(b0, 1'b1, req.eor);
			FMT_RGB565: push_px({p[15:11], 3'b0}, {p[10:5], 2'b0}, {p[4:0], 3'b0}, 8'hFF,
				1'b1, req.eor);
			FMT_RGB24: push_px(b2, b1, b0, 8'hFF, 1'b1, req.eor);
			FMT_BGR24: push_px(b0, b1, b2, 8'hFF, 1'b1, req.eor);
			FMT_RGBA32: begin
				if (b3 == 8'h00)
					push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, req.eor);
				else
					push_px(unpremultiply(b2, b3), unpremultiply(b1, b3),
						unpremultiply(b0, b3), b3, 1'b1, req.eor);
			end
			default: push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, req.eor);
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		rgba_px_t want;
		if (arst_n === 1'b1 && rgba.valid === 1'b1 && rgba.ready === 1'b1) begin
			if (pixels_due.size() == 0) begin
				$error("pixel transfer with nothing expected");
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				check_field("out_red", want.red, rgba.out_red);
				check_field("out_green", want.green, rgba.out_green);
				check_field("out_blue", want.blue, rgba.out_blue);
				check_field("out_alpha", want.alpha, rgba.out_alpha);
				check_field("run_last", {7'h00, want.last}, {7'h00, rgba.run_last});
				check_field("row_done", {7'h00, want.row}, {7'h00, rgba.row_done});
			end
		end
	end

	// output back-pressure; a long hold is requested by test_output_hold
	initial begin : rgba_ready_drive
		int n;
		rgba.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
			end else begin
				n = draw_gap(recv_idle_pct);
			end
			if (n > 0) begin
				rgba.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rgba.ready <= 1'b1;
		end
	end

	task automatic send_req(input pix_req_t req);
		int gap;
		pix.valid        <= 1'b1;
		pix.op           <= req.op;
		pix.pixel_word   <= req.word;
		pix.single_pixel <= req.single;
		pix.end_of_row   <= req.eor;
		pix.entry_index  <= req.idx;
		pix.entry_red    <= req.red;
		pix.entry_green  <= req.green;
		pix.entry_blue   <= req.blue;
		do @(posedge clk); while (pix.ready !== 1'b1);
		expand_word(req);
		gap = draw_gap(send_idle_pct);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		pix.valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		// palette writes leave nothing to wait for, so cover the pipeline depth too
		repeat (12) @(posedge clk);
	endtask

	task automatic set_format(input logic [FMT_W-1:0] f);
		wait_for_drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		fmt_shadow = f;
	endtask

	function automatic pix_req_t convert_req(logic [31:0] w, logic single, logic eor);
		pix_req_t req;
		req = '0;
		req.op     = OP_CONVERT;
		req.word   = w;
		req.single = single;
		req.eor    = eor;
		return req;
	endfunction

	function automatic pix_req_t pal_req(logic [7:0] idx, logic [23:0] rgb);
		pix_req_t req;
		req = '0;
		req.op    = OP_PAL_WRITE;
		req.word  = $urandom;
		req.idx   = idx;
		req.red   = rgb[23:16];
		req.green = rgb[15:8];
		req.blue  = rgb[7:0];
		return req;
	endfunction

	function automatic pix_req_t random_req(logic [FMT_W-1:0] fmt);
		pix_req_t req;
		int pick;
		req.op     = ($urandom_range(0, 99) < 12) ? OP_PAL_WRITE : OP_CONVERT;
		req.word   = $urandom;
		req.single = 1'($urandom_range(0, 1));
		req.eor    = 1'($urandom_range(0, 1));
		req.idx    = 8'($urandom_range(0, 255));
		req.red    = 8'($urandom_range(0, 255));
		req.green  = 8'($urandom_range(0, 255));
		req.blue   = 8'($urandom_range(0, 255));
		if (fmt == FMT_RGBA32) begin
			// lean on zero and tiny alpha, where saturation shows up
			pick = $urandom_range(0, 9);
			if (pick == 0)
				req.word[31:24] = 8'h00;
			else if (pick < 3)
				req.word[31:24] = 8'($urandom_range(1, 8));
		end
		return req;
	endfunction

	// every entry gets written before any palette mode reads it
	task automatic test_palette_load();
		logic [23:0] rgb;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		for (int i = 0; i < 256; i++) begin
			rgb = (i == 0) ? 24'h000000 : (i == 255) ? 24'hFFFFFF : 24'($urandom);
			send_req(pal_req(i[7:0], rgb));
		end
	endtask

	task automatic test_pal4();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_format(FMT_PAL4);
		send_req(convert_req(32'h0000_00F0, 1'b0, 1'b1));
		send_req(convert_req(32'hFFFF_FF0F, 1'b1, 1'b0));
		send_req(convert_req(32'h0000_0000, 1'b1, 1'b1));
		send_req(convert_req(32'hFFFF_FFFF, 1'b0, 1'b0));
	endtask

	task automatic test_pal8();
		set_format(FMT_PAL8);
		send_req(convert_req(32'hFFFF_FF00, 1'b0, 1'b1));
		send_req(convert_req(32'h0000_00FF, 1'b1, 1'b0));
		send_req(convert_req(32'h1234_56A5, 1'b0, 1'b1));
	endtask

	task automatic test_rgb565();
		set_format(FMT_RGB565);
		send_req(convert_req(32'h0000_FFFF, 1'b0, 1'b1));
		send_req(convert_req(32'hFFFF_0000, 1'b0, 1'b0));
		send_req(convert_req(32'hABCD_F800, 1'b1, 1'b0));
		send_req(convert_req(32'h0000_07E0, 1'b0, 1'b1));
	endtask

	task automatic test_byte_orders();
		set_format(FMT_RGB24);
		send_req(convert_req(32'hFF12_3456, 1'b0, 1'b1));
		send_req(convert_req(32'hFFFF_FFFF, 1'b1, 1'b0));
		set_format(FMT_BGR24);
		send_req(convert_req(32'h0012_3456, 1'b0, 1'b0));
		send_req(convert_req(32'h00FF_00FF, 1'b0, 1'b1));
	endtask

	task automatic test_unpremultiply();
		set_format(FMT_RGBA32);
		send_req(convert_req(32'h00FF_FFFF, 1'b0, 1'b1));
		send_req(convert_req(32'hFFFF_FFFF, 1'b0, 1'b0));
		send_req(convert_req(32'h01FF_0001, 1'b1, 1'b1));
		send_req(convert_req(32'h80FF_4020, 1'b0, 1'b0));
	endtask

	task automatic test_undefined_formats();
		set_format(FMT_UNDEF_6);
		send_req(convert_req(32'hFFFF_FFFF, 1'b0, 1'b1));
		set_format(FMT_UNDEF_7);
		send_req(convert_req(32'h8040_2010, 1'b1, 1'b0));
	endtask

	// output held off long enough that the pipeline fills and stalls its input
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_format(FMT_RGB24);
		hold_request = 80;
		repeat (40) send_req(random_req(FMT_RGB24));
	endtask

	// sender stops mid-stream until every pixel has come back
	task automatic test_sender_pause();
		send_idle_pct = 25;
		recv_idle_pct = 25;
		set_format(FMT_PAL4);
		repeat (30) send_req(random_req(FMT_PAL4));
		wait_for_drain();
		repeat (30) send_req(random_req(FMT_PAL4));
	endtask

	task automatic test_random_phases();
		logic [FMT_W-1:0] fmt;
		int styles [3] = '{0, 25, 50};
		for (int ph = 0; ph < 12; ph++) begin
			fmt = (ph < 8) ? ph[FMT_W-1:0] : FMT_W'($urandom_range(0, 5));
			send_idle_pct = styles[$urandom_range(0, 2)];
			recv_idle_pct = styles[$urandom_range(0, 2)];
			set_format(fmt);
			repeat (55) send_req(random_req(fmt));
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= FMT_PAL4;
		pix.valid        <= 1'b0;
		pix.op           <= OP_CONVERT;
		pix.pixel_word   <= '0;
		pix.single_pixel <= 1'b0;
		pix.end_of_row   <= 1'b0;
		pix.entry_index  <= '0;
		pix.entry_red    <= '0;
		pix.entry_green  <= '0;
		pix.entry_blue   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_palette_load();
		test_pal4();
		test_pal8();
		test_rgb565();
		test_byte_orders();
		test_unpremultiply();
		test_undefined_formats();
		test_output_hold();
		test_sender_pause();
		test_random_phases();
		wait_for_drain();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
sv/ptrc_pkg.sv
sv/ptrc_if.sv
sv/ptrc_palette.sv
sv/ptrc_unpremul.sv
sv/pixel_to_rgba8888_converter.sv
verif/pixel_to_rgba8888_converter_tb.sv
